/* rtl/core/rc4_pkg.sv */
// rc4 stream cipher shared types, constants and state encoding
package rc4_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned PERM_DEPTH   = 256;
	localparam int unsigned KEY_MAX_DEF  = 256;
	localparam logic [BYTE_W-1:0] LAST_IDX = 8'hFF;

	// opcode values of an input request
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [BYTE_W-1:0] value;
		logic              key_last;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_K4,
		ST_D2,
		ST_D3,
		ST_D4,
		ST_OUTW
	} state_t;

endpackage

/* rtl/core/rc4_stream_cipher.sv */
// rc4 stream cipher top level with permutation and key memories
//
// Input channel (in_valid/in_ready/in_item) takes key bytes and data bytes.
// Key bytes are stored in order; the byte with key_last set starts the key
// schedule: a table fill of the permutation, then 256 swap steps, during
// which in_ready is low. Key bytes past KEY_MAX_BYTES are dropped.
// Each data byte is one request, whose steps are set by the single read and
// single write port of the permutation memory: read S[i], read S[j], swap
// writes, and the keystream read overlapped with the first swap write.
// The result leaves through an output register (out_valid/out_ready/
// out_item); a data byte sent before any key gives error=1, out_byte=0
// right from the idle state. Key bytes give no result.
// If the receiver stalls, the finished result waits in a holding register
// and the block takes no new request until the output register frees up.
// Reset clears indices, key length and the keyed flag; the permutation and
// key memories are not cleared, nor need be, as neither is read before
// being written.
module rc4_stream_cipher #(
	parameter int unsigned KEY_MAX_BYTES = rc4_pkg::KEY_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rc4_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rc4_pkg::out_item_t  out_item
);

	localparam int unsigned KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
	localparam int unsigned KLW = KAW + 1;
	localparam int unsigned BW  = rc4_pkg::BYTE_W;
	localparam logic [KLW-1:0] KEY_CAP = KLW'(KEY_MAX_BYTES);

	// memories
	logic [BW-1:0] perm_mem [rc4_pkg::PERM_DEPTH];
	logic [BW-1:0] key_mem  [KEY_MAX_BYTES];

	// control state
	rc4_pkg::state_t state_q, state_d;
	logic            keyed_q;
	logic [KLW-1:0]  klen_q;
	logic [BW-1:0]   i_q, j_q, n_q;
	logic            out_valid_q;

	// payload registers
	logic [KAW-1:0]       kidx_q;
	logic [BW-1:0]        a_q, b_q, k_q, val_q;
	logic [BW-1:0]        p_rdata, k_rdata;
	rc4_pkg::out_item_t   res_q, out_q;

	// memory port controls and output load
	logic               p_we;
	logic [BW-1:0]      p_waddr, p_wdata, p_raddr;
	logic               out_load;
	rc4_pkg::out_item_t out_data;

	logic               in_acc, slot_free;
	logic               key_wr;
	logic [BW-1:0]      jn_key, jn_data, k_sum, ks_byte;
	rc4_pkg::out_item_t err_item, data_item;

	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign key_wr    = in_acc && (in_item.opcode == rc4_pkg::OP_KEY) && (klen_q < KEY_CAP);

	// index arithmetic
	assign jn_key  = j_q + p_rdata + k_rdata;
	assign jn_data = j_q + p_rdata;
	assign k_sum   = a_q + p_rdata;

	// keystream byte with forwarding of the swap writes not yet seen by the read
	always_comb begin
		if (k_q == j_q) begin
			ks_byte = a_q;
		end else if (k_q == i_q) begin
			ks_byte = b_q;
		end else begin
			ks_byte = p_rdata;
		end
	end

	assign err_item  = '{out_byte: '0, error: 1'b1};
	assign data_item = '{out_byte: val_q ^ ks_byte, error: 1'b0};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_item.opcode == rc4_pkg::OP_KEY) begin
						if (in_item.key_last) begin
							state_d = rc4_pkg::ST_INIT;
						end
					end else if (keyed_q) begin
						state_d = rc4_pkg::ST_D2;
					end else if (!slot_free) begin
						state_d = rc4_pkg::ST_OUTW;
					end
				end
			end
			rc4_pkg::ST_INIT: begin
				if (n_q == rc4_pkg::LAST_IDX) begin
					state_d = rc4_pkg::ST_K1;
				end
			end
			rc4_pkg::ST_K1: state_d = rc4_pkg::ST_K2;
			rc4_pkg::ST_K2: state_d = rc4_pkg::ST_K3;
			rc4_pkg::ST_K3: state_d = rc4_pkg::ST_K4;
			rc4_pkg::ST_K4: begin
				state_d = (n_q == rc4_pkg::LAST_IDX) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K1;
			end
			rc4_pkg::ST_D2: state_d = rc4_pkg::ST_D3;
			rc4_pkg::ST_D3: state_d = rc4_pkg::ST_D4;
			rc4_pkg::ST_D4: begin
				state_d = slot_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_OUTW;
			end
			rc4_pkg::ST_OUTW: begin
				if (slot_free) begin
					state_d = rc4_pkg::ST_IDLE;
				end
			end
			default: state_d = rc4_pkg::ST_IDLE;
		endcase
	end

	// memory accesses, handshake and output load per state
	always_comb begin
		in_ready = 1'b0;
		p_we     = 1'b0;
		p_waddr  = n_q;
		p_wdata  = a_q;
		p_raddr  = n_q;
		out_load = 1'b0;
		out_data = res_q;
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				p_raddr  = i_q + BW'(1);
				out_data = err_item;
				out_load = in_acc && (in_item.opcode == rc4_pkg::OP_DATA) && !keyed_q
					&& slot_free;
			end
			rc4_pkg::ST_INIT: begin
				p_we    = 1'b1;
				p_wdata = n_q;
			end
			rc4_pkg::ST_K1: p_raddr = n_q;
			rc4_pkg::ST_K2: p_raddr = jn_key;
			rc4_pkg::ST_K3: begin
				p_we    = 1'b1;
				p_wdata = p_rdata;
			end
			rc4_pkg::ST_K4: begin
				p_we    = 1'b1;
				p_waddr = j_q;
			end
			rc4_pkg::ST_D2: p_raddr = jn_data;
			rc4_pkg::ST_D3: begin
				p_we    = 1'b1;
				p_waddr = i_q;
				p_wdata = p_rdata;
				p_raddr = k_sum;
			end
			rc4_pkg::ST_D4: begin
				p_we     = 1'b1;
				p_waddr  = j_q;
				out_data = data_item;
				out_load = slot_free;
			end
			rc4_pkg::ST_OUTW: out_load = slot_free;
			default: ;
		endcase
	end

	// permutation memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (p_we) begin
			perm_mem[p_waddr] <= p_wdata;
		end
		p_rdata <= perm_mem[p_raddr];
	end

	// key memory
	always_ff @(posedge clk) begin
		if (key_wr) begin
			key_mem[klen_q[KAW-1:0]] <= in_item.value;
		end
		k_rdata <= key_mem[kidx_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc4_pkg::ST_IDLE;
			keyed_q     <= 1'b0;
			klen_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rc4_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (in_item.opcode == rc4_pkg::OP_KEY) begin
							if (key_wr) begin
								klen_q <= klen_q + KLW'(1);
							end
							if (in_item.key_last) begin
								n_q <= '0;
								j_q <= '0;
							end
						end else if (keyed_q) begin
							i_q <= i_q + BW'(1);
						end
					end
				end
				rc4_pkg::ST_INIT: n_q <= n_q + BW'(1);
				rc4_pkg::ST_K2:   j_q <= jn_key;
				rc4_pkg::ST_K4: begin
					n_q <= n_q + BW'(1);
					if (n_q == rc4_pkg::LAST_IDX) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
						klen_q  <= '0;
					end
				end
				rc4_pkg::ST_D2: j_q <= jn_data;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_data;
		end
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				if (in_acc) begin
					val_q <= in_item.value;
					res_q <= err_item;
					if (in_item.key_last) begin
						kidx_q <= '0;
					end
				end
			end
			rc4_pkg::ST_K2: a_q <= p_rdata;
			rc4_pkg::ST_K4: begin
				// key index cycles through the stored key by its length
				if ((KLW'(kidx_q) + KLW'(1)) == klen_q) begin
					kidx_q <= '0;
				end else begin
					kidx_q <= kidx_q + KAW'(1);
				end
			end
			rc4_pkg::ST_D2: a_q <= p_rdata;
			rc4_pkg::ST_D3: begin
				b_q <= p_rdata;
				k_q <= k_sum;
			end
			rc4_pkg::ST_D4: res_q <= data_item;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* rtl/core/rc4_checker.sv */
// port-level checks for the rc4 stream cipher, bound to the top level
module rc4_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input rc4_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input rc4_pkg::out_item_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// an error result carries a zero byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.error |-> out_item.out_byte == '0)
		else $error("error result with nonzero byte");

	// the final key byte starts the schedule, which blocks new requests
	a_sched_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.opcode == rc4_pkg::OP_KEY) && in_item.key_last
		|=> !in_ready ##1 !in_ready)
		else $error("request taken during key schedule");

	// an ordinary key byte is stored without leaving idle
	a_key_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.opcode == rc4_pkg::OP_KEY) && !in_item.key_last
		|=> in_ready)
		else $error("key byte stalled the input");

	// a key byte gives no result
	a_key_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.opcode == rc4_pkg::OP_KEY) && !out_valid
		|=> !out_valid)
		else $error("result from a key byte");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

/* verif/tb_rc4_stream_cipher.sv */
// testbench for the rc4 stream cipher: directed table, random key loads and data runs, self-checked
module tb_rc4_stream_cipher;

	localparam int unsigned KEY_CAP      = rc4_pkg::KEY_MAX_DEF;
	localparam int unsigned REQ_TARGET   = 800;
	localparam int unsigned LONG_HOLD    = 200;
	localparam int unsigned LIMIT_CYCLES = 800_000;
	localparam int unsigned REPORT_MAX   = 10;

	// one row of the directed table: the request, whether its result is typed in, and that result
	typedef struct packed {
		rc4_pkg::in_item_t  req;
		logic               typed;
		rc4_pkg::out_item_t want;
	} dir_row_t;

	localparam int DIR_N = 20;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// data before any key: error with zero byte, key_last on data ignored
		{rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
		{rc4_pkg::OP_DATA, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},
		{rc4_pkg::OP_DATA, 8'hA5, 1'b0, 1'b1, 8'h00, 1'b1},
		// three-byte key, then data
		{rc4_pkg::OP_KEY,  8'h4B, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_KEY,  8'h65, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_KEY,  8'h79, 1'b1, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'h50, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'h6C, 1'b1, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		// key bytes while the old permutation is still in use
		{rc4_pkg::OP_KEY,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'hAA, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
		// one-byte keys at both extremes
		{rc4_pkg::OP_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_KEY,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
		{rc4_pkg::OP_DATA, 8'hFE, 1'b1, 1'b0, 8'h00, 1'b0}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	rc4_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	rc4_pkg::out_item_t out_item;

	// sender side info that travels with the request on the bus
	logic               req_typed;
	rc4_pkg::out_item_t req_want;

	logic quiet     = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_taken = 1'b0;

	// cipher state mirror
	logic [7:0] sbox [256];
	logic [7:0] key_bytes [256];
	logic [8:0] key_len = '0;
	logic [7:0] ks_i = '0;
	logic [7:0] ks_j = '0;
	logic       keyed = 1'b0;

	rc4_pkg::out_item_t cipher_q [$];
	int unsigned fail_count    = 0;
	int unsigned sent_reqs     = 0;
	int unsigned key_loads     = 0;
	int unsigned dropped_bytes = 0;
	int unsigned data_results  = 0;
	int unsigned error_results = 0;
	int unsigned cycle_count   = 0;

	rc4_stream_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// key schedule over the stored bytes, cycling by key length
	function automatic void schedule_key();
		int unsigned len;
		logic [7:0] acc;
		logic [7:0] t;
		len = (key_len == 0) ? 1 : key_len;
		acc = '0;
		for (int n = 0; n < 256; n++)
			sbox[n] = n[7:0];
		for (int n = 0; n < 256; n++) begin
			acc = acc + sbox[n] + key_bytes[n % len];
			t = sbox[n];
			sbox[n] = sbox[acc];
			sbox[acc] = t;
		end
		ks_i = '0;
		ks_j = '0;
		keyed = 1'b1;
		key_len = '0;
		key_loads++;
	endfunction

	// advance the cipher state by one request and work out its result
	function automatic void rc4_advance(input rc4_pkg::in_item_t req, output logic gives,
			output logic dropped, output rc4_pkg::out_item_t res);
		logic [7:0] t;
		logic [7:0] idx;
		gives = 1'b0;
		dropped = 1'b0;
		res = '0;
		if (req.opcode == rc4_pkg::OP_KEY) begin
			if (key_len < KEY_CAP) begin
				key_bytes[key_len[7:0]] = req.value;
				key_len = key_len + 1'b1;
			end else begin
				dropped = 1'b1;
				dropped_bytes++;
			end
			if (req.key_last)
				schedule_key();
		end else if (!keyed) begin
			gives = 1'b1;
			res.error = 1'b1;
			error_results++;
		end else begin
			ks_i = ks_i + 1'b1;
			ks_j = ks_j + sbox[ks_i];
			t = sbox[ks_i];
			sbox[ks_i] = sbox[ks_j];
			sbox[ks_j] = t;
			idx = sbox[ks_i] + sbox[ks_j];
			gives = 1'b1;
			res.out_byte = req.value ^ sbox[idx];
			data_results++;
		end
	endfunction

	function automatic void note_failure(input string msg);
		if (fail_count < REPORT_MAX)
			$display("[%0d] %s", cycle_count, msg);
		fail_count++;
	endfunction

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count, cipher_q.size());
			$display("tb_rc4_stream_cipher NOT OK");
			$finish;
		end
	end

	// accepted requests feed the mirror, accepted results are checked
	always @(posedge clk) begin
		logic               gives;
		logic               dropped;
		rc4_pkg::out_item_t res;
		rc4_pkg::out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				rc4_advance(in_item, gives, dropped, res);
				if (gives)
					cipher_q.push_back(req_typed ? req_want : res);
				if (!dropped)
					sent_reqs++;
			end
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					note_failure($sformatf("unexpected result byte=%02h error=%0b",
						out_item.out_byte, out_item.error));
				end else begin
					want = cipher_q.pop_front();
					if (out_item.out_byte !== want.out_byte || out_item.error !== want.error)
						note_failure($sformatf("result mismatch: want byte=%02h error=%0b, got byte=%02h error=%0b",
							want.out_byte, want.error, out_item.out_byte, out_item.error));
				end
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int unsigned stall_left;
		int unsigned run_left;
		stall_left = 0;
		run_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && run_left == 0 && !quiet) begin
				stall_left = $urandom_range(1, 13);
				run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 12);
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (run_left != 0)
					run_left--;
			end
		end
	end

	// offer one request, with an occasional idle burst first
	task automatic offer(input rc4_pkg::in_item_t req, input logic typed,
			input rc4_pkg::out_item_t want);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		in_item   <= req;
		req_typed <= typed;
		req_want  <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering and wait for every pending result
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (cipher_q.size() != 0)
			@(posedge clk);
	endtask

	// key of the given length with random bytes, last one marked
	task automatic load_key(input int unsigned len);
		rc4_pkg::in_item_t req;
		for (int unsigned k = 0; k < len; k++) begin
			req.opcode = rc4_pkg::OP_KEY;
			req.value = $urandom_range(0, 255);
			req.key_last = (k == len - 1);
			offer(req, 1'b0, '0);
		end
	endtask

	// data bytes, now and then with a stray key_last
	task automatic data_run(input int unsigned len);
		rc4_pkg::in_item_t req;
		for (int unsigned k = 0; k < len; k++) begin
			req.opcode = rc4_pkg::OP_DATA;
			req.value = $urandom_range(0, 255);
			req.key_last = ($urandom_range(0, 7) == 0);
			offer(req, 1'b0, '0);
		end
	endtask

	initial begin
		int unsigned       scen;
		int unsigned       pick;
		int unsigned       klen;
		logic              paused;
		rc4_pkg::in_item_t req;
		scen = 0;
		paused = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		req_typed = 1'b0;
		req_want = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed table
		for (int r = 0; r < DIR_N; r++)
			offer(DIR_ROWS[r].req, DIR_ROWS[r].typed, DIR_ROWS[r].want);
		drain();

		// random key loads and data runs
		while (sent_reqs < REQ_TARGET) begin
			if (sent_reqs >= REQ_TARGET - 120)
				quiet = 1'b1;
			if (scen == 0) begin
				// full-length key
				load_key(KEY_CAP);
				data_run($urandom_range(4, 20));
			end else if (scen == 1) begin
				// overlong key whose marked byte is dropped
				load_key($urandom_range(KEY_CAP + 10, KEY_CAP + 44));
				data_run($urandom_range(4, 20));
			end else if (!hold_req && sent_reqs > 250) begin
				// receiver holds off while data keeps coming
				hold_req = 1'b1;
				data_run(16);
			end else if (!paused && sent_reqs > 450) begin
				paused = 1'b1;
				drain();
				data_run($urandom_range(1, 6));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					case ($urandom_range(0, 39))
						0: klen = KEY_CAP;
						1: klen = $urandom_range(KEY_CAP + 1, KEY_CAP + 44);
						default: klen = $urandom_range(1, 16);
					endcase
					load_key(klen);
					data_run($urandom_range(1, 30));
				end else if (pick < 85) begin
					// key bytes arriving while the current key is in use
					klen = $urandom_range(1, 3);
					for (int unsigned k = 0; k < klen; k++) begin
						req.opcode = rc4_pkg::OP_KEY;
						req.value = $urandom_range(0, 255);
						req.key_last = 1'b0;
						offer(req, 1'b0, '0);
					end
					data_run($urandom_range(1, 8));
				end else begin
					data_run($urandom_range(1, 10));
				end
			end
			scen++;
		end
		data_run(8);
		drain();
		repeat (32) @(posedge clk);

		if (cipher_q.size() != 0)
			note_failure($sformatf("%0d results never arrived", cipher_q.size()));
		$display("covered %0d key schedules (%0d key bytes beyond the limit dropped),",
			key_loads, dropped_bytes);
		$display("%0d keystream bytes and %0d unkeyed errors in %0d cycles, %0d failures",
			data_results, error_results, cycle_count, fail_count);
		if (fail_count == 0)
			$display("tb_rc4_stream_cipher OK");
		else
			$display("tb_rc4_stream_cipher NOT OK");
		$finish;
	end

endmodule
